// ===== rtl/bkt_pkg.sv =====
package bkt_pkg;

    typedef logic [1:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_INSERT_KEEP    = 2'd0;
    localparam action_t ACT_INSERT_REPLACE = 2'd1;
    localparam action_t ACT_LOOKUP_FIRST   = 2'd2;
    localparam action_t ACT_LOOKUP_SECOND  = 2'd3;

    localparam status_t ST_DONE = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_KEPT = 2'd2;
    localparam status_t ST_FULL = 2'd3;

endpackage

// ===== rtl/bkt_in_reg.sv =====
module bkt_in_reg
    import bkt_pkg::*;
#(
    parameter int FIRST_KEY_BITS  = 16,
    parameter int SECOND_KEY_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  action_t                    s_action,
    input  logic [FIRST_KEY_BITS-1:0]  s_first_key,
    input  logic [SECOND_KEY_BITS-1:0] s_second_key,
    input  logic                       advance,
    output logic                       req_valid,
    output action_t                    req_action,
    output logic [FIRST_KEY_BITS-1:0]  req_first_key,
    output logic [SECOND_KEY_BITS-1:0] req_second_key
);

    logic                       valid_reg;
    logic                       valid_next;
    action_t                    action_reg;
    logic [FIRST_KEY_BITS-1:0]  first_key_reg;
    logic [SECOND_KEY_BITS-1:0] second_key_reg;

    // the held request leaves when the table stage takes it
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg     <= s_action;
            first_key_reg  <= s_first_key;
            second_key_reg <= s_second_key;
        end
    end

    assign req_valid      = valid_reg;
    assign req_action     = action_reg;
    assign req_first_key  = first_key_reg;
    assign req_second_key = second_key_reg;

endmodule

// ===== rtl/bkt_table.sv =====
module bkt_table
    import bkt_pkg::*;
#(
    parameter int ENTRIES         = 16,
    parameter int FIRST_KEY_BITS  = 16,
    parameter int SECOND_KEY_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       go,
    input  action_t                    req_action,
    input  logic [FIRST_KEY_BITS-1:0]  req_first_key,
    input  logic [SECOND_KEY_BITS-1:0] req_second_key,
    output status_t                    res_status,
    output logic [FIRST_KEY_BITS-1:0]  res_found_first,
    output logic [SECOND_KEY_BITS-1:0] res_found_second
);

    logic [ENTRIES-1:0]         valid_reg;
    logic [ENTRIES-1:0]         valid_next;
    logic [FIRST_KEY_BITS-1:0]  first_store_reg  [ENTRIES];
    logic [SECOND_KEY_BITS-1:0] second_store_reg [ENTRIES];

    logic [ENTRIES-1:0]         eq_first;
    logic [ENTRIES-1:0]         eq_second;
    logic [ENTRIES-1:0]         hit_first;
    logic [ENTRIES-1:0]         hit_second;
    logic [ENTRIES-1:0]         valid_kept;
    logic [ENTRIES-1:0]         hit_first_kept;
    logic [ENTRIES-1:0]         free_map;
    logic [ENTRIES-1:0]         alloc_map;
    logic [ENTRIES-1:0]         wr_first;
    logic [ENTRIES-1:0]         wr_second;
    logic [FIRST_KEY_BITS-1:0]  sel_first;
    logic [SECOND_KEY_BITS-1:0] sel_second;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            eq_first[i]  = (first_store_reg[i] == req_first_key);
            eq_second[i] = (second_store_reg[i] == req_second_key);
        end
    end

    assign hit_first  = valid_reg & eq_first;
    assign hit_second = valid_reg & eq_second;

    // replace drops the entry holding the second key before anything else
    assign valid_kept     = (req_action == ACT_INSERT_REPLACE) ? (valid_reg & ~hit_second)
                                                               : valid_reg;
    assign hit_first_kept = valid_kept & eq_first;
    assign free_map       = ~valid_kept;
    // lowest free entry, one-hot
    assign alloc_map      = free_map & (~free_map + {{(ENTRIES-1){1'b0}}, 1'b1});

    always_comb begin
        sel_first  = '0;
        sel_second = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_second[i]) begin
                sel_first = sel_first | first_store_reg[i];
            end
            if (hit_first[i]) begin
                sel_second = sel_second | second_store_reg[i];
            end
        end
    end

    always_comb begin
        valid_next       = valid_reg;
        wr_first         = '0;
        wr_second        = '0;
        res_status       = ST_DONE;
        res_found_first  = '0;
        res_found_second = '0;
        case (req_action)
            ACT_INSERT_KEEP: begin
                if ((|hit_first) || (|hit_second)) begin
                    res_status = ST_KEPT;
                end else if (|free_map) begin
                    valid_next = valid_kept | alloc_map;
                    wr_first   = alloc_map;
                    wr_second  = alloc_map;
                end else begin
                    res_status = ST_FULL;
                end
            end
            ACT_INSERT_REPLACE: begin
                valid_next = valid_kept;
                if (|hit_first_kept) begin
                    wr_second = hit_first_kept;
                end else if (|free_map) begin
                    valid_next = valid_kept | alloc_map;
                    wr_first   = alloc_map;
                    wr_second  = alloc_map;
                end else begin
                    res_status = ST_FULL;
                end
            end
            ACT_LOOKUP_FIRST: begin
                if (|hit_first) begin
                    res_found_second = sel_second;
                end else begin
                    res_status = ST_MISS;
                end
            end
            ACT_LOOKUP_SECOND: begin
                if (|hit_second) begin
                    res_found_first = sel_first;
                end else begin
                    res_status = ST_MISS;
                end
            end
            default: begin
                res_status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (go) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (go && wr_first[i]) begin
                first_store_reg[i] <= req_first_key;
            end
            if (go && wr_second[i]) begin
                second_store_reg[i] <= req_second_key;
            end
        end
    end

`ifndef SYNTH
    // keys stay unique across valid entries
    a_first_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_first))
        else $error("first key held by more than one entry");

    a_second_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_second))
        else $error("second key held by more than one entry");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        go && res_status == ST_FULL |-> &valid_reg)
        else $error("full reported with a free entry");

    a_lookup_keeps_table: assert property (@(posedge aclk) disable iff (!aresetn)
        go && (req_action == ACT_LOOKUP_FIRST || req_action == ACT_LOOKUP_SECOND)
        |=> valid_reg == $past(valid_reg))
        else $error("lookup changed table occupancy");
`endif

endmodule

// ===== rtl/bidirectional_key_table_core.sv =====
// bidirectional key table: up to ENTRIES pairs, both keys unique
// s_ channel: one request per handshake (action, first key, second key)
//   insert-or-keep, insert-or-replace, lookup by first, lookup by second
// m_ channel: exactly one result per request, in request order
//   status, found_first (reverse lookup), found_second (forward lookup)
// path: an accepted request waits in the input register, then the table acts
//   on it and its result is loaded into the output register for m_
// throughput: one request per cycle while m_ready is high; each request
//   sees the table as left by the one before, since the table updates at
//   the edge that loads the result; all entries are compared in parallel, so
//   the result timing does not depend on ENTRIES or on the action
// reset (aresetn low, synchronous): table empty, both channels idle
// stall: while m_ready is low the result holds, one further request waits
//   in the input register, and s_ready then drops
module bidirectional_key_table_core
    import bkt_pkg::*;
#(
    parameter int ENTRIES         = 16,
    parameter int FIRST_KEY_BITS  = 16,
    parameter int SECOND_KEY_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [FIRST_KEY_BITS-1:0]  s_first_key,
    input  logic [SECOND_KEY_BITS-1:0] s_second_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [FIRST_KEY_BITS-1:0]  m_found_first,
    output logic [SECOND_KEY_BITS-1:0] m_found_second
);

    logic                       req_valid;
    action_t                    req_action;
    logic [FIRST_KEY_BITS-1:0]  req_first_key;
    logic [SECOND_KEY_BITS-1:0] req_second_key;
    logic                       advance;

    status_t                    res_status;
    logic [FIRST_KEY_BITS-1:0]  res_found_first;
    logic [SECOND_KEY_BITS-1:0] res_found_second;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    status_t                    status_reg;
    logic [FIRST_KEY_BITS-1:0]  found_first_reg;
    logic [SECOND_KEY_BITS-1:0] found_second_reg;

    assign advance        = req_valid && (!out_valid_reg || m_ready);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    bkt_in_reg #(
        .FIRST_KEY_BITS  (FIRST_KEY_BITS),
        .SECOND_KEY_BITS (SECOND_KEY_BITS)
    ) u_in_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_first_key    (s_first_key),
        .s_second_key   (s_second_key),
        .advance        (advance),
        .req_valid      (req_valid),
        .req_action     (req_action),
        .req_first_key  (req_first_key),
        .req_second_key (req_second_key)
    );

    bkt_table #(
        .ENTRIES         (ENTRIES),
        .FIRST_KEY_BITS  (FIRST_KEY_BITS),
        .SECOND_KEY_BITS (SECOND_KEY_BITS)
    ) u_table (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .go               (advance),
        .req_action       (req_action),
        .req_first_key    (req_first_key),
        .req_second_key   (req_second_key),
        .res_status       (res_status),
        .res_found_first  (res_found_first),
        .res_found_second (res_found_second)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg       <= res_status;
            found_first_reg  <= res_found_first;
            found_second_reg <= res_found_second;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_found_first  = found_first_reg;
    assign m_found_second = found_second_reg;

`ifndef SYNTH
    // a found key comes back only with a found status
    a_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && status_reg != ST_DONE
        |-> found_first_reg == '0 && found_second_reg == '0)
        else $error("returned key on a result that found nothing");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("pending result overwritten");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bkt_pkg::*;

    localparam int ENTRIES         = 16;
    localparam int FIRST_KEY_BITS  = 16;
    localparam int SECOND_KEY_BITS = 8;
    localparam int POOL_DEPTH      = 24;
    localparam int EPISODES        = 10;
    localparam int EPISODE_LEN     = 115;

    typedef logic [FIRST_KEY_BITS-1:0]  first_key_t;
    typedef logic [SECOND_KEY_BITS-1:0] second_key_t;

    typedef struct packed {
        status_t     status;
        first_key_t  first;
        second_key_t second;
    } result_t;

    typedef struct packed {
        action_t     act;
        first_key_t  k1;
        second_key_t k2;
        logic        pinned;
        result_t     pin;
    } request_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    action_t     s_action       = ACT_LOOKUP_FIRST;
    first_key_t  s_first_key    = '0;
    second_key_t s_second_key   = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    status_t     m_status;
    first_key_t  m_found_first;
    second_key_t m_found_second;

    // typed expectation travelling with the request, used in place of the predictor's result
    logic        s_pinned       = 1'b0;
    result_t     s_pin          = '0;

    logic        pair_live [ENTRIES];
    first_key_t  pair_first [ENTRIES];
    second_key_t pair_second [ENTRIES];

    result_t     awaited_results[$];
    request_t    directed_rows[$];
    int          mismatch_count = 0;
    int          burst_left     = 0;
    logic [6:0]  stall_tick     = '0;
    logic [2:0]  stall_mode     = '0;

    bidirectional_key_table_core #(
        .ENTRIES         (ENTRIES),
        .FIRST_KEY_BITS  (FIRST_KEY_BITS),
        .SECOND_KEY_BITS (SECOND_KEY_BITS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_first_key    (s_first_key),
        .s_second_key   (s_second_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_first  (m_found_first),
        .m_found_second (m_found_second)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            pair_live[i]   = 1'b0;
            pair_first[i]  = '0;
            pair_second[i] = '0;
        end
    end

    task automatic log_mismatch(input string what);
        mismatch_count++;
        $display("ERROR %0t ns: %s", $time, what);
    endtask

    function automatic int slot_of_first(input first_key_t k1);
        for (int i = 0; i < ENTRIES; i++)
            if (pair_live[i] && pair_first[i] == k1)
                return i;
        return -1;
    endfunction

    function automatic int slot_of_second(input second_key_t k2);
        for (int i = 0; i < ENTRIES; i++)
            if (pair_live[i] && pair_second[i] == k2)
                return i;
        return -1;
    endfunction

    // lowest free entry takes the new pair
    function automatic status_t claim_slot(input first_key_t k1, input second_key_t k2);
        for (int i = 0; i < ENTRIES; i++)
            if (!pair_live[i]) begin
                pair_live[i]   = 1'b1;
                pair_first[i]  = k1;
                pair_second[i] = k2;
                return ST_DONE;
            end
        return ST_FULL;
    endfunction

    function automatic result_t bimap_predict(input action_t act, input first_key_t k1,
                                              input second_key_t k2);
        result_t r;
        int      by_first;
        int      by_second;
        r         = '0;
        r.status  = ST_DONE;
        by_first  = slot_of_first(k1);
        by_second = slot_of_second(k2);
        case (act)
            ACT_INSERT_KEEP: begin
                if (by_first >= 0 || by_second >= 0)
                    r.status = ST_KEPT;
                else
                    r.status = claim_slot(k1, k2);
            end
            ACT_INSERT_REPLACE: begin
                if (by_second >= 0)
                    pair_live[by_second] = 1'b0;
                by_first = slot_of_first(k1);
                if (by_first >= 0)
                    pair_second[by_first] = k2;
                else
                    r.status = claim_slot(k1, k2);
            end
            ACT_LOOKUP_FIRST: begin
                if (by_first >= 0)
                    r.second = pair_second[by_first];
                else
                    r.status = ST_MISS;
            end
            default: begin
                if (by_second >= 0)
                    r.first = pair_first[by_second];
                else
                    r.status = ST_MISS;
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input action_t act, input first_key_t k1, input second_key_t k2,
                           input logic pinned, input status_t st, input first_key_t ff,
                           input second_key_t fs);
        request_t row;
        row.act        = act;
        row.k1         = k1;
        row.k2         = k2;
        row.pinned     = pinned;
        row.pin.status = st;
        row.pin.first  = ff;
        row.pin.second = fs;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input request_t row);
        logic taken;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_action     <= row.act;
        s_first_key  <= row.k1;
        s_second_key <= row.k2;
        s_pinned     <= row.pinned;
        s_pin        <= row.pin;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_ready;
        end
        @(negedge aclk);
    endtask

    // result side stalls in modes that change each time stall_tick wraps
    always @(negedge aclk) begin
        if (stall_tick == 0)
            stall_mode <= 3'($urandom_range(0, 4));
        stall_tick <= stall_tick + 1'b1;
        case (stall_mode)
            3'd0:    m_ready <= 1'b1;
            3'd1:    m_ready <= 1'($urandom_range(0, 1));
            3'd2:    m_ready <= (stall_tick[1:0] == 2'd0);
            3'd3:    m_ready <= ($urandom_range(0, 7) != 0);
            default: m_ready <= (stall_tick[5:4] == 2'd0);
        endcase
    end

    always @(posedge aclk) begin : scoreboard
        result_t want;
        result_t guess;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    log_mismatch($sformatf("result with no request pending: status %0d",
                                           m_status));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status)
                        log_mismatch($sformatf("status %0d, expected %0d",
                                               m_status, want.status));
                    if (m_found_first !== want.first)
                        log_mismatch($sformatf("found_first %h, expected %h",
                                               m_found_first, want.first));
                    if (m_found_second !== want.second)
                        log_mismatch($sformatf("found_second %h, expected %h",
                                               m_found_second, want.second));
                end
            end
            if (s_valid && s_ready) begin
                guess = bimap_predict(s_action, s_first_key, s_second_key);
                if (s_pinned)
                    guess = s_pin;
                awaited_results.insert(awaited_results.size(), guess);
            end
        end
    end

    initial begin : stimulus
        request_t    row;
        first_key_t  first_pool [POOL_DEPTH];
        second_key_t second_pool [POOL_DEPTH];
        int          pool_size;
        int          roll;
        logic        churn;

        // empty table, then one pair at the extremes
        add_row(ACT_LOOKUP_FIRST,   16'h0000, 8'h00, 1'b1, ST_MISS, 16'h0000, 8'h00);
        add_row(ACT_LOOKUP_SECOND,  16'h0000, 8'h00, 1'b1, ST_MISS, 16'h0000, 8'h00);
        add_row(ACT_INSERT_KEEP,    16'hFFFF, 8'hFF, 1'b1, ST_DONE, 16'h0000, 8'h00);
        add_row(ACT_LOOKUP_FIRST,   16'hFFFF, 8'h00, 1'b1, ST_DONE, 16'h0000, 8'hFF);
        add_row(ACT_LOOKUP_SECOND,  16'h0000, 8'hFF, 1'b1, ST_DONE, 16'hFFFF, 8'h00);
        // key clashes on keep
        add_row(ACT_INSERT_KEEP,    16'hFFFF, 8'h00, 1'b1, ST_KEPT, 16'h0000, 8'h00);
        add_row(ACT_INSERT_KEEP,    16'h0000, 8'hFF, 1'b1, ST_KEPT, 16'h0000, 8'h00);
        // replace evicts by second key, then same pair again
        add_row(ACT_INSERT_REPLACE, 16'h0000, 8'hFF, 1'b0, ST_DONE, 16'h0000, 8'h00);
        add_row(ACT_INSERT_REPLACE, 16'h0000, 8'hFF, 1'b0, ST_DONE, 16'h0000, 8'h00);
        // fill remaining entries
        for (int i = 1; i < ENTRIES; i++)
            add_row(ACT_INSERT_KEEP, 16'hA500 + 16'(i), 8'h20 + 8'(i), 1'b0,
                    ST_DONE, 16'h0000, 8'h00);
        add_row(ACT_INSERT_KEEP,    16'h5555, 8'hAA, 1'b1, ST_FULL, 16'h0000, 8'h00);
        add_row(ACT_INSERT_REPLACE, 16'h5556, 8'hAB, 1'b1, ST_FULL, 16'h0000, 8'h00);
        // replace moving a second key across entries
        add_row(ACT_INSERT_REPLACE, 16'hA501, 8'h22, 1'b0, ST_DONE, 16'h0000, 8'h00);
        add_row(ACT_LOOKUP_SECOND,  16'h0000, 8'h21, 1'b0, ST_DONE, 16'h0000, 8'h00);
        add_row(ACT_LOOKUP_FIRST,   16'hA502, 8'h00, 1'b0, ST_DONE, 16'h0000, 8'h00);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // random requests drawn mostly from small key pools so that keys collide
        for (int ep = 0; ep < EPISODES; ep++) begin
            pool_size = $urandom_range(10, POOL_DEPTH);
            for (int i = 0; i < POOL_DEPTH; i++) begin
                first_pool[i]  = first_key_t'($urandom);
                second_pool[i] = second_key_t'($urandom);
            end
            first_pool[0]  = '0;
            first_pool[1]  = '1;
            second_pool[0] = '0;
            second_pool[1] = '1;
            churn = ep[0];
            repeat (EPISODE_LEN) begin
                row  = '0;
                roll = $urandom_range(0, 99);
                if (churn) begin
                    if (roll < 10)      row.act = ACT_INSERT_KEEP;
                    else if (roll < 50) row.act = ACT_INSERT_REPLACE;
                    else if (roll < 75) row.act = ACT_LOOKUP_FIRST;
                    else                row.act = ACT_LOOKUP_SECOND;
                end else begin
                    if (roll < 50)      row.act = ACT_INSERT_KEEP;
                    else if (roll < 70) row.act = ACT_INSERT_REPLACE;
                    else if (roll < 85) row.act = ACT_LOOKUP_FIRST;
                    else                row.act = ACT_LOOKUP_SECOND;
                end
                row.k1 = ($urandom_range(0, 6) == 0) ? first_key_t'($urandom)
                                                     : first_pool[$urandom_range(0, pool_size - 1)];
                row.k2 = ($urandom_range(0, 6) == 0) ? second_key_t'($urandom)
                                                     : second_pool[$urandom_range(0, pool_size - 1)];
                send_request(row);
            end
        end

        s_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
